FILE: design/mts_pkg.sv
// Package for the transition sampler: command and status codes, register indexes,
// queue item layout and shared constants. Used by every design file.
package mts_pkg;

    localparam int MAX_RATINGS_DEF = 16;
    localparam int FIELD_LIMIT     = 16;
    localparam int ONE_Q16         = 65536;
    localparam int COUNT_W         = 5;
    localparam int PROB_W          = 18;
    localparam int DRAW_W          = 16;
    localparam int TOL_W           = 17;
    localparam int CFG_W           = 17;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } mts_cmd_t;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_INDEX  = 2'd1,
        STS_VALUE  = 2'd2,
        STS_REDEF  = 2'd3
    } mts_status_t;

    typedef enum logic {
        REG_RATING_COUNT = 1'b0,
        REG_TOLERANCE    = 1'b1
    } mts_reg_t;

    typedef struct packed {
        mts_cmd_t            cmd;
        logic [3:0]          from_rating;
        logic [3:0]          to_rating;
        logic [PROB_W-1:0]   probability;
        logic [DRAW_W-1:0]   uniform_draw;
        mts_status_t         status;
        logic [COUNT_W-1:0]  count;
    } mts_op_t;

    typedef struct packed {
        logic    valid;
        mts_op_t op;
    } mts_head_t;

    function automatic int field_lim(int m);
        return (m < FIELD_LIMIT) ? m : FIELD_LIMIT;
    endfunction

endpackage

FILE: design/mts_front.sv
// Front end of the transition sampler: range and value checks on incoming items
// and a two-entry queue towards the back end. Depends on mts_pkg.
module mts_front
    import mts_pkg::*;
#(
    parameter int MAX_RATINGS = MAX_RATINGS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [47:0]         s_tdata,
    input  logic                s_tuser,
    input  logic [COUNT_W-1:0]  rating_count,
    input  logic [TOL_W-1:0]    tolerance,
    output mts_head_t           head,
    input  logic                pop
);

    localparam int LIM = field_lim(MAX_RATINGS);

    mts_op_t              op_in;
    logic [COUNT_W-1:0]   cnt;
    logic [TOL_W-1:0]     tol_c;
    logic signed [18:0]   prob_x;
    logic signed [18:0]   lo_bound;
    logic signed [18:0]   hi_bound;
    logic                 idx_bad;
    logic                 val_bad;

    mts_op_t              entry_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           fill_reg, fill_next;
    logic                 push;

    always_comb begin
        if (rating_count == '0) begin
            cnt = COUNT_W'(1);
        end else if (rating_count > COUNT_W'(LIM)) begin
            cnt = COUNT_W'(LIM);
        end else begin
            cnt = rating_count;
        end
        tol_c    = (tolerance > TOL_W'(ONE_Q16)) ? TOL_W'(ONE_Q16) : tolerance;
        prob_x   = $signed({s_tdata[25], s_tdata[25:8]});
        lo_bound = -$signed({2'b00, tol_c});
        hi_bound = $signed(19'(ONE_Q16)) + $signed({2'b00, tol_c});

        op_in.cmd          = mts_cmd_t'(s_tuser);
        op_in.from_rating  = s_tdata[3:0];
        op_in.to_rating    = s_tdata[7:4];
        op_in.probability  = s_tdata[25:8];
        op_in.uniform_draw = s_tdata[41:26];
        op_in.count        = cnt;

        idx_bad = ({1'b0, op_in.from_rating} >= cnt)
               || ((op_in.cmd == CMD_WRITE) && ({1'b0, op_in.to_rating} >= cnt));
        val_bad = (op_in.cmd == CMD_WRITE) && ((prob_x < lo_bound) || (prob_x > hi_bound));

        priority if (idx_bad) begin
            op_in.status = STS_INDEX;
        end else if (val_bad) begin
            op_in.status = STS_VALUE;
        end else begin
            op_in.status = STS_OK;
        end
    end

    assign s_tready = (fill_reg != 2'd2);
    assign push     = s_tvalid && s_tready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= op_in;
        end
    end

    assign head.valid = (fill_reg != 2'd0);
    assign head.op    = entry_reg[rd_ptr_reg];

endmodule

FILE: design/mts_back.sv
// Back end of the transition sampler: probability table, defined marks, row walk
// for samples and the result register. Depends on mts_pkg.
module mts_back
    import mts_pkg::*;
#(
    parameter int MAX_RATINGS = MAX_RATINGS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  mts_head_t  head,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);

    localparam int LIM   = field_lim(MAX_RATINGS);
    localparam int DEPTH = LIM * LIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int SUM_W = PROB_W + 4;

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_WALK = 2'b10
    } bk_state_t;

    bk_state_t            state_reg, state_next;

    logic [PROB_W-1:0]    mem [DEPTH];
    logic [DEPTH-1:0]     defined_reg;
    logic [PROB_W-1:0]    rd_data_reg;
    logic                 def_rd_reg;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic [AW-1:0]        wr_addr;

    logic [3:0]           row_reg, row_next;
    logic [DRAW_W-1:0]    draw_reg, draw_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [COUNT_W-1:0]   issue_reg, issue_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [3:0]           rd_col_reg, rd_col_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SUM_W-1:0] sum_add;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [3:0]           next_rating_reg, next_rating_next;
    mts_status_t          status_reg, status_next;

    logic                 out_free;
    logic                 hit;
    logic                 last_col;
    logic                 finish;

    assign out_free = !m_tvalid_reg || m_tready;
    assign wr_addr  = AW'(head.op.from_rating) * AW'(LIM) + AW'(head.op.to_rating);
    assign rd_addr  = AW'(row_reg) * AW'(LIM) + AW'(issue_reg);

    always_comb begin
        sum_add  = sum_reg + (def_rd_reg ? SUM_W'($signed(rd_data_reg)) : '0);
        hit      = $signed({{(SUM_W-DRAW_W){1'b0}}, draw_reg}) < sum_add;
        last_col = ({1'b0, rd_col_reg} == (cnt_reg - COUNT_W'(1)));
        finish   = rd_vld_reg && (hit || last_col);
    end

    always_comb begin
        state_next       = state_reg;
        pop              = 1'b0;
        mem_we           = 1'b0;
        rd_en            = 1'b0;
        row_next         = row_reg;
        draw_next        = draw_reg;
        cnt_next         = cnt_reg;
        issue_next       = issue_reg;
        rd_vld_next      = 1'b0;
        rd_col_next      = rd_col_reg;
        sum_next         = sum_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        next_rating_next = next_rating_reg;
        status_next      = status_reg;

        unique case (state_reg)
            BK_IDLE: begin
                if (head.valid && out_free) begin
                    pop = 1'b1;
                    if (head.op.status != STS_OK) begin
                        m_tvalid_next    = 1'b1;
                        next_rating_next = 4'd0;
                        status_next      = head.op.status;
                    end else if (head.op.cmd == CMD_WRITE) begin
                        m_tvalid_next    = 1'b1;
                        next_rating_next = 4'd0;
                        if (defined_reg[wr_addr]) begin
                            status_next = STS_REDEF;
                        end else begin
                            status_next = STS_OK;
                            mem_we      = 1'b1;
                        end
                    end else begin
                        row_next   = head.op.from_rating;
                        draw_next  = head.op.uniform_draw;
                        cnt_next   = head.op.count;
                        issue_next = '0;
                        sum_next   = '0;
                        state_next = BK_WALK;
                    end
                end
            end
            BK_WALK: begin
                if (rd_vld_reg) begin
                    sum_next = sum_add;
                end
                if (finish) begin
                    m_tvalid_next    = 1'b1;
                    next_rating_next = rd_col_reg;
                    status_next      = STS_OK;
                    state_next       = BK_IDLE;
                end else if (issue_reg < cnt_reg) begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_col_next = issue_reg[3:0];
                    issue_next  = issue_reg + COUNT_W'(1);
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            defined_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            if (mem_we) begin
                defined_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        row_reg         <= row_next;
        draw_reg        <= draw_next;
        cnt_reg         <= cnt_next;
        issue_reg       <= issue_next;
        rd_col_reg      <= rd_col_next;
        sum_reg         <= sum_next;
        next_rating_reg <= next_rating_next;
        status_reg      <= status_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= head.op.probability;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            def_rd_reg  <= defined_reg[rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, status_reg, next_rating_reg};

endmodule

FILE: design/markov_transition_sampler.sv
// Path: a write or rejected item goes through the two-entry queue and then the
// result register; a sample first walks its row from column 0 to the column where it stops.
// Throughput: one write per cycle while m_tready is high; a sample holds the back end
// until its row walk ends, which reads the single table read port once per column.
// Reset clears the defined marks, the queue and the result register, and sets
// rating_count to 16 and tolerance to 0; table contents are not cleared.
module markov_transition_sampler
    import mts_pkg::*;
#(
    parameter int MAX_RATINGS = MAX_RATINGS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // from_rating, to_rating, probability, uniform_draw
    input  logic              s_tuser,   // command
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // next_rating, status
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    logic [COUNT_W-1:0]  rating_count_reg, rating_count_next;
    logic [TOL_W-1:0]    tolerance_reg, tolerance_next;
    mts_head_t           head;
    logic                pop;

    always_comb begin
        rating_count_next = rating_count_reg;
        tolerance_next    = tolerance_reg;
        if (cfg_we) begin
            unique case (mts_reg_t'(cfg_index))
                REG_RATING_COUNT: rating_count_next = cfg_wdata[COUNT_W-1:0];
                REG_TOLERANCE:    tolerance_next    = cfg_wdata[TOL_W-1:0];
                default:          rating_count_next = rating_count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rating_count_reg <= COUNT_W'(16);
            tolerance_reg    <= '0;
        end else begin
            rating_count_reg <= rating_count_next;
            tolerance_reg    <= tolerance_next;
        end
    end

    mts_front #(
        .MAX_RATINGS (MAX_RATINGS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .rating_count (rating_count_reg),
        .tolerance    (tolerance_reg),
        .head         (head),
        .pop          (pop)
    );

    mts_back #(
        .MAX_RATINGS (MAX_RATINGS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
